FILE: sv/percent_escape_decoder_core_assert.svh
`ifndef PERCENT_ESCAPE_DECODER_CORE_ASSERT_SVH
`define PERCENT_ESCAPE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ped_pkg.sv
package ped_pkg;

  // Most bytes one request can release
  localparam int MaxOut = 3;
  localparam int CntW   = 2;

  // Group queue between classifier and serializer
  localparam int QDepth = 4;
  localparam int QAw    = 2;
  localparam int QCntW  = 3;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChLa    = 8'h61;
  localparam logic [7:0] ChLf    = 8'h66;
  localparam logic [7:0] ChUa    = 8'h41;
  localparam logic [7:0] ChUf    = 8'h46;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_PCT   = 2'd1,
    MODE_DIGIT = 2'd2
  } mode_t;

  // Decoded bytes released by one request, oldest in slot 0
  typedef struct packed {
    logic [CntW-1:0]        cnt;
    logic [MaxOut-1:0][7:0] data;
    logic                   last;
  } grp_t;

endpackage

FILE: sv/ped_front.sv
module ped_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic          fire,
  output ped_pkg::grp_t grp,
  output logic          grp_valid
);
  import ped_pkg::*;

  mode_t       mode_r, mode_nxt, mode_pend;
  logic [7:0]  held_r, held_nxt;
  logic        hex_b, hex_h, do_plain;
  logic [CntW-1:0] n;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= Ch0 && c <= Ch9) || (c >= ChLa && c <= ChLf) ||
             (c >= ChUa && c <= ChUf);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    hex_val = (c <= Ch9) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  assign hex_b = is_hex(in_byte);
  assign hex_h = is_hex(held_r);

  // Next state: escape tracking, then close out on the last byte
  always_comb begin
    do_plain  = 1'b0;
    mode_pend = MODE_PLAIN;
    held_nxt  = held_r;
    case (mode_r)
      MODE_PCT: begin
        if (hex_b) begin
          mode_pend = MODE_DIGIT;
          held_nxt  = in_byte;
        end else begin
          do_plain = 1'b1;
        end
      end
      MODE_DIGIT: begin
        if (!(hex_b && hex_h)) do_plain = 1'b1;
      end
      default: do_plain = 1'b1;
    endcase
    if (do_plain && in_byte == ChPct) mode_pend = MODE_PCT;
    mode_nxt = mode_pend;
    if (in_last) begin
      mode_nxt = MODE_PLAIN;
      held_nxt = '0;
    end
  end

  // Outputs: collect released bytes in order
  always_comb begin
    n         = '0;
    grp       = '0;
    grp.last  = in_last;
    case (mode_r)
      MODE_PCT: begin
        if (!hex_b) begin
          grp.data[n] = ChPct;
          n = n + 1'b1;
        end
      end
      MODE_DIGIT: begin
        if (hex_b && hex_h) begin
          grp.data[n] = {hex_val(held_r), hex_val(in_byte)};
          n = n + 1'b1;
        end else begin
          grp.data[n] = ChPct;
          n = n + 1'b1;
          grp.data[n] = held_r;
          n = n + 1'b1;
        end
      end
      default: ;
    endcase
    if (do_plain && in_byte != ChPct) begin
      grp.data[n] = (in_byte == ChPlus) ? ChSpace : in_byte;
      n = n + 1'b1;
    end
    // Flush an escape cut short by the end of the string
    if (in_last && mode_pend == MODE_PCT) begin
      grp.data[n] = ChPct;
      n = n + 1'b1;
    end else if (in_last && mode_pend == MODE_DIGIT) begin
      grp.data[n] = ChPct;
      n = n + 1'b1;
      grp.data[n] = in_byte;
      n = n + 1'b1;
    end
    grp.cnt   = n;
    grp_valid = (n != '0);
  end

  // Advance escape state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      held_r <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

FILE: sv/ped_queue.sv
module ped_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ped_pkg::grp_t wr_data,
  output logic          full,
  input  logic          pop,
  output ped_pkg::grp_t rd_data,
  output logic          empty
);
  import ped_pkg::*;

  grp_t             mem_r [QDepth];
  logic [QAw-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCntW-1:0] count_r;

  assign full    = (count_r == QCntW'(QDepth));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Store groups
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: sv/ped_back.sv
module ped_back (
  input  logic          clk,
  input  logic          rst_n,
  input  ped_pkg::grp_t head,
  input  logic          head_empty,
  output logic          head_pop,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_empty,
  input  logic          out_pop
);
  import ped_pkg::*;

  logic [CntW-1:0] idx_r;
  logic            at_end;

  assign at_end    = (idx_r == head.cnt - 1'b1);
  assign out_byte  = head.data[idx_r];
  assign out_last  = head.last && at_end;
  assign out_empty = head_empty;
  assign head_pop  = out_pop && !head_empty && at_end;

  // Step through the head group one byte per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (out_pop && !head_empty) begin
      idx_r <= at_end ? '0 : idx_r + 1'b1;
    end
  end

endmodule

FILE: sv/percent_escape_decoder_core.sv
// The front works combinationally, the queue registers each released group, and the
// serializer shows the queue head on out_*. A request is accepted every cycle while the
// queue is not full; the serializer hands out one byte per cycle while pop is high, and
// a four-group queue lets the front run ahead while a multi-byte group is served.
// Reset: synchronous active-low rst_n empties the queue and returns to plain text mode.
`include "percent_escape_decoder_core_assert.svh"

module percent_escape_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       empty,
  input  logic       pop
);
  import ped_pkg::*;

  grp_t fr_grp, q_head;
  logic fr_valid, fire, q_push, q_full, q_pop, q_empty;

  assign full   = q_full;
  assign fire   = push && !q_full;
  assign q_push = fire && fr_valid;

  // Classify bytes and track escapes
  ped_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .fire     (fire),
    .grp      (fr_grp),
    .grp_valid(fr_valid)
  );

  // Hold released groups
  ped_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(fr_grp),
    .full   (q_full),
    .pop    (q_pop),
    .rd_data(q_head),
    .empty  (q_empty)
  );

  // Serialize groups onto the result port
  ped_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .head_empty(q_empty),
    .head_pop  (q_pop),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_empty (empty),
    .out_pop   (pop)
  );

  `PED_ASSERT_NOW(a_last_releases, fire && in_last, q_push, "last byte released nothing")
  `PED_ASSERT_NOW(a_grp_nonempty, q_push, fr_grp.cnt != '0, "empty group queued")
  `PED_ASSERT_NOW(a_pop_on_last, q_pop && q_head.last, out_last, "group end lost last flag")
  `PED_ASSERT_NEXT(a_push_not_empty, q_push, !empty, "queued group not visible")

endmodule
